// ===== src/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps

package u16u8_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] SURR_MASK   = 16'hFC00;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;
   localparam logic [20:0] SUPP_OFFSET = 21'h10000;

   localparam logic [20:0] LIMIT_1BYTE = 21'h00080;
   localparam logic [20:0] LIMIT_2BYTE = 21'h00800;
   localparam logic [20:0] LIMIT_3BYTE = 21'h10000;

   localparam logic [7:0] LEAD_2BYTE = 8'hC0;
   localparam logic [7:0] LEAD_3BYTE = 8'hE0;
   localparam logic [7:0] LEAD_4BYTE = 8'hF0;
   localparam logic [7:0] CONT_BYTE  = 8'h80;

   // One queued character: a code point, or a broken-pair error marker.
   typedef struct packed {
      logic        bad;
      logic [20:0] code_point;
   } job_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

// ===== src/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
// Takes one UTF-16 code unit per beat and returns the UTF-8 bytes of each
// complete character, one byte per beat, with char_done on the last byte.
// A unit is accepted every cycle while the character queue has room; the
// back end emits one byte per cycle while rsp_stall is low, so a BMP unit
// yields one to three bytes and a surrogate pair four bytes over two units.
// Output bandwidth (one byte per cycle) sets the sustained rate. A high
// surrogate followed by anything but a low surrogate yields one bad_pair
// beat, after which units are dropped until end_of_string clears all state.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_utf8_byte,
   output logic        rsp_char_done,
   output logic        rsp_bad_pair
);

   logic                queue_full, push, pop;
   u16u8_pkg::job_type  push_job;
   u16u8_pkg::head_type head;

   assign req_stall = queue_full;

   u16u8_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   u16u8_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_utf8_byte (rsp_utf8_byte),
      .rsp_char_done (rsp_char_done),
      .rsp_bad_pair  (rsp_bad_pair)
   );

endmodule

// ===== src/u16u8_front.sv =====
// Front end: accepts code units, pairs surrogates and queues characters.
`timescale 1ns / 1ps

module u16u8_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [15:0]        req_code_unit,
   input  logic               req_end_of_string,
   input  logic               queue_full,
   output logic               push,
   output u16u8_pkg::job_type push_job
);

   logic [9:0] held_high_bits_ff, held_high_bits_in;
   logic       high_pending_ff, high_pending_in;
   logic       halted_ff, halted_in;
   logic       accept, is_high, is_low, emit;

   assign accept  = req_valid && !queue_full;
   assign is_high = (req_code_unit & u16u8_pkg::SURR_MASK) == u16u8_pkg::HIGH_SURR;
   assign is_low  = (req_code_unit & u16u8_pkg::SURR_MASK) == u16u8_pkg::LOW_SURR;

   always_comb begin
      held_high_bits_in = held_high_bits_ff;
      high_pending_in   = high_pending_ff;
      halted_in         = halted_ff;
      emit              = 1'b0;
      push_job.bad        = 1'b0;
      push_job.code_point = {5'd0, req_code_unit};
      if (halted_ff) begin
         emit = 1'b0;
      end else if (high_pending_ff) begin
         emit              = 1'b1;
         high_pending_in   = 1'b0;
         held_high_bits_in = 10'd0;
         if (is_low) begin
            push_job.code_point = {1'b0, held_high_bits_ff, req_code_unit[9:0]}
                                  + u16u8_pkg::SUPP_OFFSET;
         end else begin
            push_job.bad = 1'b1;
            halted_in    = 1'b1;
         end
      end else if (is_high) begin
         held_high_bits_in = req_code_unit[9:0];
         high_pending_in   = 1'b1;
      end else begin
         emit = 1'b1;
      end
      if (req_end_of_string) begin
         held_high_bits_in = 10'd0;
         high_pending_in   = 1'b0;
         halted_in         = 1'b0;
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_high_bits_ff <= 10'd0;
         high_pending_ff   <= 1'b0;
         halted_ff         <= 1'b0;
      end else if (accept) begin
         held_high_bits_ff <= held_high_bits_in;
         high_pending_ff   <= high_pending_in;
         halted_ff         <= halted_in;
      end
   end

endmodule

// ===== src/u16u8_queue.sv =====
// Short character queue between the front and back ends.
`timescale 1ns / 1ps

module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u16u8_pkg::job_type  push_job,
   input  logic                pop,
   output logic                full,
   output u16u8_pkg::head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u16u8_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head.valid = count_ff != '0;
   assign head.job   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/u16u8_back.sv =====
// Back end: serializes each queued character into UTF-8 byte beats.
`timescale 1ns / 1ps

module u16u8_back (
   input  logic                clock,
   input  logic                reset,
   input  u16u8_pkg::head_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_utf8_byte,
   output logic                rsp_char_done,
   output logic                rsp_bad_pair
);

   logic [1:0]  idx_ff;
   logic        rsp_valid_ff;
   logic [7:0]  byte_ff;
   logic        done_ff, bad_ff;
   logic [1:0]  last_idx, remain;
   logic [20:0] cp;
   logic [7:0]  byte_in;
   logic        last, load;

   assign cp = head.job.code_point;

   always_comb begin
      if (head.job.bad || cp < u16u8_pkg::LIMIT_1BYTE) begin
         last_idx = 2'd0;
      end else if (cp < u16u8_pkg::LIMIT_2BYTE) begin
         last_idx = 2'd1;
      end else if (cp < u16u8_pkg::LIMIT_3BYTE) begin
         last_idx = 2'd2;
      end else begin
         last_idx = 2'd3;
      end
   end

   assign remain = last_idx - idx_ff;
   assign last   = idx_ff == last_idx;

   always_comb begin
      byte_in = 8'd0;
      if (head.job.bad) begin
         byte_in = 8'd0;
      end else if (idx_ff == 2'd0) begin
         case (last_idx)
            2'd0:    byte_in = {1'b0, cp[6:0]};
            2'd1:    byte_in = u16u8_pkg::LEAD_2BYTE | {3'd0, cp[10:6]};
            2'd2:    byte_in = u16u8_pkg::LEAD_3BYTE | {4'd0, cp[15:12]};
            default: byte_in = u16u8_pkg::LEAD_4BYTE | {5'd0, cp[20:18]};
         endcase
      end else begin
         case (remain)
            2'd0:    byte_in = u16u8_pkg::CONT_BYTE | {2'd0, cp[5:0]};
            2'd1:    byte_in = u16u8_pkg::CONT_BYTE | {2'd0, cp[11:6]};
            default: byte_in = u16u8_pkg::CONT_BYTE | {2'd0, cp[17:12]};
         endcase
      end
   end

   assign load = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         done_ff <= last;
         bad_ff  <= head.job.bad;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_utf8_byte = byte_ff;
   assign rsp_char_done = done_ff;
   assign rsp_bad_pair  = bad_ff;

endmodule

// ===== tb/sv/utf16_to_utf8_transcoder_test.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 transcoder, with random beat gaps and stalls.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_test;

   localparam logic [15:0] SURR_MASK   = 16'hFC00;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;
   localparam logic [20:0] SUPP_OFFSET = 21'h10000;
   localparam logic [7:0]  LEAD_2      = 8'hC0;
   localparam logic [7:0]  LEAD_3      = 8'hE0;
   localparam logic [7:0]  LEAD_4      = 8'hF0;
   localparam logic [7:0]  CONT        = 8'h80;
   localparam int          RANDOM_UNITS = 410;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_string;
   } unit_beat_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       char_done;
      logic       bad_pair;
   } utf8_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_code_unit = '0;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_utf8_byte;
   logic        rsp_char_done;
   logic        rsp_bad_pair;

   unit_beat_type pending_units[$];
   utf8_beat_type expected_bytes[$];

   logic [9:0] held_high_bits = '0;
   logic       high_pending = 1'b0;
   logic       halted_on_error = 1'b0;

   int fail_count = 0;
   int cycle_count = 0;
   int send_wait = 0;
   int recv_wait = 0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;

   utf16_to_utf8_transcoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_utf8_byte     (rsp_utf8_byte),
      .rsp_char_done     (rsp_char_done),
      .rsp_bad_pair      (rsp_bad_pair)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic push_utf8(input logic [7:0] value, input logic done, input logic bad);
      utf8_beat_type b;
      b.utf8_byte = value;
      b.char_done = done;
      b.bad_pair  = bad;
      expected_bytes.push_back(b);
   endtask

   task automatic encode_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         push_utf8(cp[7:0], 1'b1, 1'b0);
      end else if (cp < 21'h800) begin
         push_utf8(LEAD_2 | {3'b000, cp[10:6]}, 1'b0, 1'b0);
         push_utf8(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0);
      end else if (cp < SUPP_OFFSET) begin
         push_utf8(LEAD_3 | {4'b0000, cp[15:12]}, 1'b0, 1'b0);
         push_utf8(CONT | {2'b00, cp[11:6]}, 1'b0, 1'b0);
         push_utf8(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0);
      end else begin
         push_utf8(LEAD_4 | {5'b00000, cp[20:18]}, 1'b0, 1'b0);
         push_utf8(CONT | {2'b00, cp[17:12]}, 1'b0, 1'b0);
         push_utf8(CONT | {2'b00, cp[11:6]}, 1'b0, 1'b0);
         push_utf8(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0);
      end
   endtask

   task automatic transcode_unit(input logic [15:0] unit, input logic eos);
      logic [20:0] cp;
      if (halted_on_error) begin
      end else if (high_pending) begin
         if ((unit & SURR_MASK) == LOW_SURR) begin
            cp = {1'b0, held_high_bits, unit[9:0]} + SUPP_OFFSET;
            encode_code_point(cp);
         end else begin
            push_utf8(8'h00, 1'b1, 1'b1);
            halted_on_error = 1'b1;
         end
         high_pending   = 1'b0;
         held_high_bits = '0;
      end else if ((unit & SURR_MASK) == HIGH_SURR) begin
         held_high_bits = unit[9:0];
         high_pending   = 1'b1;
      end else begin
         encode_code_point({5'b00000, unit});
      end
      if (eos) begin
         held_high_bits  = '0;
         high_pending    = 1'b0;
         halted_on_error = 1'b0;
      end
   endtask

   task automatic queue_unit(input logic [15:0] unit, input logic eos);
      unit_beat_type u;
      u.code_unit     = unit;
      u.end_of_string = eos;
      pending_units.push_back(u);
   endtask

   function automatic logic [15:0] random_plain_unit();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(16'h0000, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hD7FF));
         3: return 16'($urandom_range(16'hE000, 16'hFFFF));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Strings of random length, mostly well-formed, with some broken pairs and lone surrogates.
   task automatic queue_random_strings(input int count);
      int queued;
      int len;
      int kind;
      logic [15:0] unit;
      logic last;
      queued = 0;
      while (queued < count) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
               queue_unit(random_plain_unit(), last);
               queued++;
            end else if (kind < 16) begin
               unit = HIGH_SURR | 16'($urandom_range(0, 16'h03FF));
               if (last) begin
                  queue_unit(unit, $urandom_range(0, 3) == 0);
                  queued++;
                  if (pending_units[$].end_of_string)
                     continue;
               end else begin
                  queue_unit(unit, 1'b0);
                  queued++;
               end
               queue_unit(LOW_SURR | 16'($urandom_range(0, 16'h03FF)), last);
               queued++;
            end else if (kind < 17) begin
               queue_unit(LOW_SURR | 16'($urandom_range(0, 16'h03FF)), last);
               queued++;
            end else if (kind < 18) begin
               queue_unit(HIGH_SURR | 16'($urandom_range(0, 16'h03FF)), last);
               queued++;
            end else begin
               queue_unit(HIGH_SURR | 16'($urandom_range(0, 16'h03FF)), 1'b0);
               queue_unit(random_plain_unit(), last);
               queued += 2;
            end
         end
      end
   endtask

   // Driver.
   always @(posedge clock) begin : drive_units
      bit took;
      unit_beat_type u;
      took = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            transcode_unit(req_code_unit, req_end_of_string);
            took = 1'b1;
            if ($urandom_range(0, 31) == 0)
               send_burst = !send_burst;
            send_wait = send_burst ? 0 : $urandom_range(0, 3);
         end
         if (!req_valid || took) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_units.size() > 0) begin
               u = pending_units.pop_front();
               req_valid         <= 1'b1;
               req_code_unit     <= u.code_unit;
               req_end_of_string <= u.end_of_string;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin : check_bytes
      utf8_beat_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, byte %02h", rsp_utf8_byte));
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_utf8_byte !== e.utf8_byte)
                  report_mismatch($sformatf("utf8_byte %02h, want %02h",
                                            rsp_utf8_byte, e.utf8_byte));
               if (rsp_char_done !== e.char_done)
                  report_mismatch($sformatf("char_done %b, want %b",
                                            rsp_char_done, e.char_done));
               if (rsp_bad_pair !== e.bad_pair)
                  report_mismatch($sformatf("bad_pair %b, want %b",
                                            rsp_bad_pair, e.bad_pair));
            end
            if ($urandom_range(0, 31) == 0)
               recv_burst = !recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, 3);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      // Boundaries of each encoding length.
      queue_unit(16'h0000, 1'b0);
      queue_unit(16'h007F, 1'b0);
      queue_unit(16'h0080, 1'b0);
      queue_unit(16'h07FF, 1'b0);
      queue_unit(16'h0800, 1'b0);
      queue_unit(16'hD7FF, 1'b0);
      queue_unit(16'hE000, 1'b0);
      queue_unit(16'hFFFF, 1'b0);
      // Lone low surrogates.
      queue_unit(16'hDC00, 1'b0);
      queue_unit(16'hDFFF, 1'b0);
      // Smallest and largest pairs.
      queue_unit(16'hD800, 1'b0);
      queue_unit(16'hDC00, 1'b0);
      queue_unit(16'hDBFF, 1'b0);
      queue_unit(16'hDFFF, 1'b1);
      // Broken pair, then halted units until the end mark.
      queue_unit(16'hD800, 1'b0);
      queue_unit(16'h0041, 1'b0);
      queue_unit(16'h0042, 1'b0);
      queue_unit(16'hD801, 1'b0);
      queue_unit(16'hDC01, 1'b1);
      // High surrogate dropped at end of string.
      queue_unit(16'hDABC, 1'b1);
      queue_unit(16'h0043, 1'b0);
      // High followed by high.
      queue_unit(16'hDBFF, 1'b0);
      queue_unit(16'hD800, 1'b1);
      queue_unit(16'hFFFF, 1'b1);

      queue_random_strings(RANDOM_UNITS);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_units.size() > 0 || req_valid)
         @(posedge clock);
      while (expected_bytes.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_bytes.size() > 0)
         report_mismatch($sformatf("%0d expected beats never came", expected_bytes.size()));

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
